@@ sv/mer_pkg.sv @@
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

	localparam int PIX_W     = 14;
	localparam int CTR_W     = 12;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'd1;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RXSQ,
		ST_RYSQ,
		ST_D0,
		ST_D1,
		ST_D2,
		ST_C0,
		ST_C1,
		ST_C2,
		ST_SW0,
		ST_SW1,
		ST_SW2,
		ST_SW3,
		ST_SW4,
		ST_I1A,
		ST_I1B,
		ST_I1C,
		ST_I2A,
		ST_I2B,
		ST_I2C,
		ST_DRAIN,
		ST_EMIT
	} mer_state_t;

	typedef enum logic [3:0] {
		ACC_NONE,
		ACC_RX2,
		ACC_RY2,
		ACC_CLR,
		ACC_HOLD,
		ACC_ADD0,
		ACC_ADD2,
		ACC_SUB2,
		ACC_ADD3,
		ACC_SUB3
	} mer_acc_t;

	typedef enum logic [3:0] {
		A_RX,
		A_RY,
		A_X,
		A_Y,
		A_ONE,
		A_TX,
		A_TY,
		A_PROD,
		A_RY2
	} mer_asel_t;

	typedef enum logic [2:0] {
		B_RX,
		B_RY,
		B_RX2,
		B_RY2,
		B_TX,
		B_TY
	} mer_bsel_t;

	typedef struct packed {
		mer_asel_t a_sel;
		mer_bsel_t b_sel;
		mer_acc_t  acc;
	} mer_issue_t;

endpackage

@@ sv/mer_ifs.sv @@
// ----------------------------------------------------------------------------
// mer_cmd_if / mer_pix_if
// Valid/ready channels of the ellipse rasterizer: commands in, pixels out.
// ----------------------------------------------------------------------------
interface mer_cmd_if #(
	parameter int RADIUS_BITS = 10
) ();
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic [RADIUS_BITS-1:0] radius_x;
	logic [RADIUS_BITS-1:0] radius_y;

	modport source (output valid, func, radius_x, radius_y, input ready);
	modport sink   (input valid, func, radius_x, radius_y, output ready);
endinterface

interface mer_pix_if
	import mer_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [PIX_W-1:0] pixel_x;
	logic signed [PIX_W-1:0] pixel_y;
	logic                    last_of_run;
	logic                    ellipse_done;

	modport source (output valid, pixel_x, pixel_y, last_of_run, ellipse_done,
		input ready);
	modport sink   (input valid, pixel_x, pixel_y, last_of_run, ellipse_done,
		output ready);
endinterface

@@ sv/midpoint_ellipse_raster.sv @@
// ----------------------------------------------------------------------------
// midpoint_ellipse_raster
// Two-region midpoint ellipse pixel generator with one shared multiplier
// and accumulator under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  cmd       in   valid/ready       func, radius_x, radius_y
//  pix       out  valid/ready       pixel_x, pixel_y, last_of_run, ellipse_done
//  cfg       in   cfg_we (no wait)  cfg_index, cfg_data
//
//  Start: arithmetic (plus the region-switch steps when region two is
//  entered at once), then 5 pixels, one per cycle when pix.ready stays
//  high, then ready again. Advance: arithmetic, then 4 pixels. The single
//  multiplier is issued once a cycle. Advance with no ellipse in progress
//  is accepted with no output. pix stalls hold the sequencer in its emit
//  state; reset clears all state but the product and pixel payload registers.
// ----------------------------------------------------------------------------
module midpoint_ellipse_raster
	import mer_pkg::*;
#(
	parameter int RADIUS_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CTR_W-1:0]     cfg_data,
	mer_cmd_if.sink              cmd,
	mer_pix_if.source            pix
);

	localparam int R  = RADIUS_BITS;
	localparam int SQ = 2 * R;
	localparam int AW = 2 * R + 2;
	localparam int BW = 2 * R;
	localparam int PW = AW + BW;
	localparam int DW = 4 * R + 5;
	localparam int OW = (R > PIX_W) ? R : PIX_W;
	localparam logic [2:0] LAST_WITH_CTR = 3'd4;
	localparam logic [2:0] LAST_NO_CTR   = 3'd3;

	mer_state_t     state_q, state_nx;
	mer_issue_t     iss;
	mer_acc_t       acc_op_q;

	logic [CTR_W-1:0] ctr_x_q, ctr_y_q;
	logic [R-1:0]     rx_q, ry_q, x_q, y_q;
	logic [SQ-1:0]    rx2_q, ry2_q;
	logic [DW-1:0]    dec_q;
	logic [PW-1:0]    prod_q, cmp_q;
	logic             region_q, busy_q, step_q, center_q;
	logic [2:0]       emit_q;
	logic             ov_q;
	logic signed [PIX_W-1:0] px_q, py_q;
	logic             last_q, done_q;

	logic          accept, lt, ld, last_now, neg, pos;
	logic [R:0]    tx;
	logic [R-1:0]  ty;
	logic [AW-1:0] a_op;
	logic [BW-1:0] b_op;
	logic [DW-1:0] addend;
	logic          sub;
	logic [2:0]    mir;
	logic [OW-1:0] ox_w, oy_w;
	logic [PIX_W-1:0] cx, cy, ox, oy;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign neg       = dec_q[DW-1];
	assign pos       = !neg && (dec_q != '0);
	assign tx        = {x_q, 1'b1};
	assign ty        = y_q - 1'b1;
	assign lt        = cmp_q < prod_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x_q <= '0;
			ctr_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CENTER_X: ctr_x_q <= cfg_data;
				CFG_CENTER_Y: ctr_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.func == FUNC_START)
						state_nx = ST_RXSQ;
					else if (busy_q)
						state_nx = region_q ? ST_I2A : ST_I1A;
				end
			end
			ST_RXSQ:  state_nx = ST_RYSQ;
			ST_RYSQ:  state_nx = ST_D0;
			ST_D0:    state_nx = ST_D1;
			ST_D1:    state_nx = ST_D2;
			ST_D2:    state_nx = ST_C0;
			ST_C0:    state_nx = ST_C1;
			ST_C1:    state_nx = ST_C2;
			ST_C2:    state_nx = lt ? ST_EMIT : ST_SW0;
			ST_SW0:   state_nx = ST_SW1;
			ST_SW1:   state_nx = ST_SW2;
			ST_SW2:   state_nx = ST_SW3;
			ST_SW3:   state_nx = ST_SW4;
			ST_SW4:   state_nx = ST_DRAIN;
			ST_I1A:   state_nx = ST_I1B;
			ST_I1B:   state_nx = ST_I1C;
			ST_I1C:   state_nx = ST_C0;
			ST_I2A:   state_nx = ST_I2B;
			ST_I2B:   state_nx = ST_I2C;
			ST_I2C:   state_nx = ST_DRAIN;
			ST_DRAIN: state_nx = ST_EMIT;
			ST_EMIT:  state_nx = (ld && last_now) ? ST_IDLE : ST_EMIT;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// multiplier issue per state
	always_comb begin
		iss = '{a_sel: A_ONE, b_sel: B_RX, acc: ACC_NONE};
		unique case (state_q)
			ST_RXSQ: iss = '{a_sel: A_RX,   b_sel: B_RX,  acc: ACC_RX2};
			ST_RYSQ: iss = '{a_sel: A_RY,   b_sel: B_RY,  acc: ACC_RY2};
			ST_D0:   iss = '{a_sel: A_RY,   b_sel: B_RX2, acc: ACC_SUB2};
			ST_D1:   iss = '{a_sel: A_ONE,  b_sel: B_RX2, acc: ACC_ADD0};
			ST_D2:   iss = '{a_sel: A_ONE,  b_sel: B_RY2, acc: ACC_ADD2};
			ST_C0:   iss = '{a_sel: A_X,    b_sel: B_RY2, acc: ACC_HOLD};
			ST_C1:   iss = '{a_sel: A_Y,    b_sel: B_RX2, acc: ACC_NONE};
			ST_SW0:  iss = '{a_sel: A_TX,   b_sel: B_TX,  acc: ACC_CLR};
			ST_SW1:  iss = '{a_sel: A_PROD, b_sel: B_RY2, acc: ACC_ADD0};
			ST_SW2:  iss = '{a_sel: A_TY,   b_sel: B_TY,  acc: ACC_NONE};
			ST_SW3:  iss = '{a_sel: A_PROD, b_sel: B_RX2, acc: ACC_ADD2};
			ST_SW4:  iss = '{a_sel: A_RY2,  b_sel: B_RX2, acc: ACC_SUB2};
			ST_I1A:  iss = '{a_sel: A_X,    b_sel: B_RY2, acc: ACC_ADD3};
			ST_I1B:  iss = '{a_sel: A_ONE,  b_sel: B_RY2, acc: ACC_ADD2};
			ST_I1C:  iss = '{a_sel: A_Y,    b_sel: B_RX2,
				acc: step_q ? ACC_SUB3 : ACC_NONE};
			ST_I2A:  iss = '{a_sel: A_ONE,  b_sel: B_RX2, acc: ACC_ADD2};
			ST_I2B:  iss = '{a_sel: A_Y,    b_sel: B_RX2, acc: ACC_SUB3};
			ST_I2C:  iss = '{a_sel: A_X,    b_sel: B_RY2,
				acc: step_q ? ACC_ADD3 : ACC_NONE};
			default: ;
		endcase
	end

	always_comb begin
		case (iss.a_sel)
			A_RX:    a_op = AW'(rx_q);
			A_RY:    a_op = AW'(ry_q);
			A_X:     a_op = AW'(x_q);
			A_Y:     a_op = AW'(y_q);
			A_TX:    a_op = AW'(tx);
			A_TY:    a_op = AW'(ty);
			A_PROD:  a_op = prod_q[AW-1:0];
			A_RY2:   a_op = AW'(ry2_q);
			default: a_op = AW'(1);
		endcase
		case (iss.b_sel)
			B_RY:    b_op = BW'(ry_q);
			B_RX2:   b_op = rx2_q;
			B_RY2:   b_op = ry2_q;
			B_TX:    b_op = BW'(tx);
			B_TY:    b_op = BW'(ty);
			default: b_op = BW'(rx_q);
		endcase
	end

	// accumulator operand
	always_comb begin
		addend = DW'(prod_q);
		sub    = 1'b0;
		case (acc_op_q)
			ACC_ADD2: addend = DW'(prod_q) << 2;
			ACC_SUB2: begin
				addend = DW'(prod_q) << 2;
				sub    = 1'b1;
			end
			ACC_ADD3: addend = DW'(prod_q) << 3;
			ACC_SUB3: begin
				addend = DW'(prod_q) << 3;
				sub    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= a_op * b_op;
	end

	// datapath and sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			acc_op_q <= ACC_NONE;
			rx_q     <= '0;
			ry_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			rx2_q    <= '0;
			ry2_q    <= '0;
			dec_q    <= '0;
			cmp_q    <= '0;
			region_q <= 1'b0;
			busy_q   <= 1'b0;
			step_q   <= 1'b0;
			center_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			acc_op_q <= iss.acc;

			case (acc_op_q)
				ACC_RX2:  rx2_q <= prod_q[SQ-1:0];
				ACC_RY2:  ry2_q <= prod_q[SQ-1:0];
				ACC_CLR:  dec_q <= '0;
				ACC_HOLD: cmp_q <= prod_q;
				ACC_ADD0, ACC_ADD2, ACC_SUB2, ACC_ADD3, ACC_SUB3:
					dec_q <= sub ? dec_q - addend : dec_q + addend;
				default: ;
			endcase

			if (accept) begin
				if (cmd.func == FUNC_START) begin
					rx_q     <= cmd.radius_x;
					ry_q     <= cmd.radius_y;
					x_q      <= '0;
					y_q      <= cmd.radius_y;
					region_q <= 1'b0;
					dec_q    <= '0;
					center_q <= 1'b1;
				end else if (busy_q) begin
					center_q <= 1'b0;
					if (!region_q) begin
						step_q <= !neg;
						x_q    <= x_q + 1'b1;
						if (!neg)
							y_q <= y_q - 1'b1;
					end else begin
						step_q <= !pos;
						y_q    <= y_q - 1'b1;
						if (!pos)
							x_q <= x_q + 1'b1;
					end
				end
			end

			if (state_q == ST_C2 && lt)
				busy_q <= 1'b1;
			if (state_q == ST_SW0) begin
				region_q <= 1'b1;
				busy_q   <= (y_q != '0);
			end
			if (state_q == ST_I2A)
				busy_q <= (y_q != '0);
		end
	end

	// pixel output
	assign last_now = (emit_q == (center_q ? LAST_WITH_CTR : LAST_NO_CTR));
	assign ld       = (state_q == ST_EMIT) && (!ov_q || pix.ready);
	assign mir      = emit_q - {2'b00, center_q};
	assign ox_w     = OW'(x_q);
	assign oy_w     = OW'(y_q);
	assign ox       = ox_w[PIX_W-1:0];
	assign oy       = oy_w[PIX_W-1:0];
	assign cx       = PIX_W'(ctr_x_q);
	assign cy       = PIX_W'(ctr_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			emit_q <= '0;
		end else begin
			if (ld)
				ov_q <= 1'b1;
			else if (pix.ready)
				ov_q <= 1'b0;
			if (ld)
				emit_q <= last_now ? 3'd0 : emit_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			last_q <= last_now;
			done_q <= !busy_q;
			if (center_q && emit_q == '0) begin
				px_q <= cx;
				py_q <= cy;
			end else begin
				px_q <= mir[0] ? cx - ox : cx + ox;
				py_q <= mir[1] ? cy - oy : cy + oy;
			end
		end
	end

	assign pix.valid        = ov_q;
	assign pix.pixel_x      = px_q;
	assign pix.pixel_y      = py_q;
	assign pix.last_of_run  = last_q;
	assign pix.ellipse_done = done_q;

`ifndef SYNTHESIS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (acc_op_q == ACC_NONE))
		else $error("accumulator op pending while idle");

	a_region_switch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(region_q) |-> ($past(state_q) == ST_SW0))
		else $error("region two entered outside the switch sequence");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |->
		(emit_q <= (center_q ? LAST_WITH_CTR : LAST_NO_CTR)))
		else $error("pixel counter past the last pixel of the transaction");
`endif

endmodule
